### rtl/u2r_pkg.sv
package u2r_pkg;

    // one input transaction
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    // one output transaction
    typedef struct packed {
        logic [6:0] out_char;
        logic       run_last;
    } out_item_t;

    // what follows the hex escapes of a job
    typedef enum logic [2:0] {
        TK_NONE = 3'd0,
        TK_CHAR = 3'd1,
        TK_ESC  = 3'd2,
        TK_LINE = 3'd3,
        TK_TAB  = 3'd4,
        TK_UNIT = 3'd5
    } tail_kind_t;

    // work handed from the front to the back for one input byte
    typedef struct packed {
        logic [2:0]      hex_cnt;
        logic [3:0][7:0] hex_bytes;
        tail_kind_t      tail;
        logic [6:0]      tail_chr;
        logic [20:0]     code;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    // ascii characters
    localparam logic [6:0] CH_BSL   = 7'h5C;
    localparam logic [6:0] CH_QUOTE = 7'h27;
    localparam logic [6:0] CH_U     = 7'h75;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_QMARK = 7'h3F;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_SPACE = 7'h20;

    // lowercase hex digit
    function automatic logic [6:0] hex_digit(input logic [3:0] n);
        logic [6:0] r;
        if (n < 4'd10)
        begin
            r = CH_ZERO + {3'b000, n};
        end
        else
        begin
            r = 7'h57 + {3'b000, n};
        end
        return r;
    endfunction

    // length of the tail string
    function automatic logic [2:0] tail_len(input tail_kind_t k);
        logic [2:0] r;
        case (k)
            TK_CHAR: r = 3'd1;
            TK_ESC:  r = 3'd2;
            TK_LINE: r = 3'd6;
            TK_TAB:  r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // character at a position of the tail string
    function automatic logic [6:0] tail_char(input tail_kind_t k, input logic [6:0] c,
                                             input logic [2:0] pos);
        logic [6:0] r;
        r = c;
        case (k)
            TK_ESC:
            begin
                r = (pos == 3'd0) ? CH_BSL : c;
            end
            TK_LINE:
            begin
                case (pos)
                    3'd0:    r = CH_BSL;
                    3'd1:    r = 7'h6C;
                    3'd2:    r = 7'h69;
                    3'd3:    r = 7'h6E;
                    3'd4:    r = 7'h65;
                    default: r = CH_SPACE;
                endcase
            end
            TK_TAB:
            begin
                case (pos)
                    3'd0:    r = CH_BSL;
                    3'd1:    r = 7'h74;
                    3'd2:    r = 7'h61;
                    3'd3:    r = 7'h62;
                    default: r = CH_SPACE;
                endcase
            end
            default: r = c;
        endcase
        return r;
    endfunction

    // powers of ten for the decimal digits
    function automatic logic [16:0] pow10(input logic [2:0] idx);
        logic [16:0] r;
        case (idx)
            3'd0:    r = 17'd1;
            3'd1:    r = 17'd10;
            3'd2:    r = 17'd100;
            3'd3:    r = 17'd1000;
            default: r = 17'd10000;
        endcase
        return r;
    endfunction

    // one decimal digit and the remainder: {digit, remainder}
    function automatic logic [19:0] dec_step(input logic [15:0] mag, input logic [2:0] idx);
        logic [16:0] p;
        logic [20:0] prod;
        logic [20:0] sub;
        logic [3:0]  d;
        p   = pow10(idx);
        d   = 4'd0;
        sub = '0;
        for (int k = 1; k < 10; k++)
        begin
            prod = 21'(k) * {4'b0000, p};
            if ({5'b00000, mag} >= prod)
            begin
                d   = 4'(k);
                sub = prod;
            end
        end
        return {d, 16'({5'b00000, mag} - sub)};
    endfunction

endpackage

### rtl/u2r_queue.sv
module u2r_queue
    import u2r_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/u2r_front.sv
module u2r_front
    import u2r_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output job_t     job,
    output logic     job_push
);

    logic [20:0] acc_reg, acc_next;
    logic [1:0]  exp_reg, exp_next;
    logic [1:0]  seen_reg, seen_next;
    logic [7:0]  held_reg [3];
    logic [7:0]  held_next [3];

    logic [7:0]  b;
    logic        cont;
    logic        fresh;
    logic [2:0]  seen_inc;
    logic [20:0] acc_shift;
    logic [2:0]  cnt;

    // decode one byte into a job and the next sequence state
    always_comb
    begin
        b         = item.text_byte;
        cont      = (b[7:6] == 2'b10);
        seen_inc  = {1'b0, seen_reg} + 3'd1;
        acc_shift = {acc_reg[14:0], b[5:0]};
        acc_next  = acc_reg;
        exp_next  = exp_reg;
        seen_next = seen_reg;
        for (int k = 0; k < 3; k++)
        begin
            held_next[k] = held_reg[k];
        end
        cnt           = 3'd0;
        fresh         = 1'b1;
        job.hex_cnt   = 3'd0;
        job.hex_bytes = '0;
        job.tail      = TK_NONE;
        job.tail_chr  = b[6:0];
        job.code      = acc_shift;

        // open sequence: continue it or flush what is held
        if (exp_reg != 2'd0)
        begin
            if (cont)
            begin
                fresh = 1'b0;
                if (seen_inc >= {1'b0, exp_reg})
                begin
                    job.tail  = TK_UNIT;
                    exp_next  = 2'd0;
                    seen_next = 2'd0;
                    acc_next  = '0;
                end
                else
                begin
                    acc_next                  = acc_shift;
                    seen_next                 = seen_inc[1:0];
                    held_next[seen_inc[1:0]]  = b;
                end
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (2'(k) <= seen_reg)
                    begin
                        job.hex_bytes[cnt[1:0]] = held_reg[k];
                        cnt = cnt + 3'd1;
                    end
                end
                exp_next  = 2'd0;
                seen_next = 2'd0;
                acc_next  = '0;
            end
        end

        // byte that continues no sequence, also one that just flushed an open one
        if (fresh)
        begin
            case (b)
                8'h5C, 8'h7B, 8'h7D: job.tail = TK_ESC;
                8'h0A:               job.tail = TK_LINE;
                8'h09:               job.tail = TK_TAB;
                default:
                begin
                    if (b < 8'h20)
                    begin
                        job.tail = TK_NONE;
                    end
                    else if (b < 8'h80)
                    begin
                        job.tail = TK_CHAR;
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        exp_next     = 2'd1;
                        acc_next     = {16'd0, b[4:0]};
                        held_next[0] = b;
                        seen_next    = 2'd0;
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        exp_next     = 2'd2;
                        acc_next     = {17'd0, b[3:0]};
                        held_next[0] = b;
                        seen_next    = 2'd0;
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        exp_next     = 2'd3;
                        acc_next     = {18'd0, b[2:0]};
                        held_next[0] = b;
                        seen_next    = 2'd0;
                    end
                    else
                    begin
                        job.hex_bytes[cnt[1:0]] = b;
                        cnt = cnt + 3'd1;
                    end
                end
            endcase
        end

        // truncated sequence at end of text
        if (item.end_of_text && exp_next != 2'd0)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (2'(k) <= seen_next)
                begin
                    job.hex_bytes[cnt[1:0]] = held_next[k];
                    cnt = cnt + 3'd1;
                end
            end
            exp_next  = 2'd0;
            seen_next = 2'd0;
            acc_next  = '0;
        end

        job.hex_cnt = cnt;
        job_push    = accept && (cnt != 3'd0 || job.tail != TK_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            exp_reg  <= '0;
            seen_reg <= '0;
        end
        else if (accept)
        begin
            acc_reg  <= acc_next;
            exp_reg  <= exp_next;
            seen_reg <= seen_next;
        end
    end

    // held bytes of the open sequence
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < 3; k++)
            begin
                held_reg[k] <= held_next[k];
            end
        end
    end

endmodule

### rtl/u2r_back.sv
module u2r_back
    import u2r_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      head,
    input  logic      head_valid,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HEX  = 4'b0010,
        PH_TAIL = 4'b0100,
        PH_UNIT = 4'b1000
    } phase_t;

    // positions inside a hex escape
    localparam logic [2:0] HP_BSL = 3'd0;
    localparam logic [2:0] HP_QT  = 3'd1;
    localparam logic [2:0] HP_HI  = 3'd2;
    localparam logic [2:0] HP_LO  = 3'd3;

    // positions inside a unicode escape
    localparam logic [2:0] UP_BSL = 3'd0;
    localparam logic [2:0] UP_U   = 3'd1;
    localparam logic [2:0] UP_NEG = 3'd2;
    localparam logic [2:0] UP_DIG = 3'd3;
    localparam logic [2:0] UP_END = 3'd4;

    phase_t      phase_reg, phase_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_item_reg, out_item_next;
    job_t        job_reg, job_next;
    logic [1:0]  idx_reg, idx_next;
    logic [2:0]  pos_reg, pos_next;
    logic        unit_sel_reg, unit_sel_next;
    logic        two_reg, two_next;
    logic        neg_reg, neg_next;
    logic [15:0] cur_reg, cur_next;
    logic [15:0] u1_reg, u1_next;
    logic [15:0] mag_reg, mag_next;
    logic [2:0]  pow_reg, pow_next;

    logic        adv;
    logic        last_c;
    logic [6:0]  char_c;
    logic [7:0]  hb;
    logic [19:0] step;
    logic        head_two;
    phase_t      first_phase;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign adv       = (phase_reg != PH_IDLE) && (!out_valid_reg || out_ready);
    assign pop       = head_valid && ((phase_reg == PH_IDLE) || (adv && last_c));

    // character of the current step and end-of-job detect
    always_comb
    begin
        hb     = job_reg.hex_bytes[idx_reg];
        step   = dec_step(mag_reg, pow_reg);
        char_c = CH_SPACE;
        last_c = 1'b0;
        unique case (phase_reg)
            PH_HEX:
            begin
                case (pos_reg)
                    HP_BSL:  char_c = CH_BSL;
                    HP_QT:   char_c = CH_QUOTE;
                    HP_HI:   char_c = hex_digit(hb[7:4]);
                    default: char_c = hex_digit(hb[3:0]);
                endcase
                last_c = (pos_reg == HP_LO) && ({1'b0, idx_reg} + 3'd1 == job_reg.hex_cnt)
                         && (job_reg.tail == TK_NONE);
            end
            PH_TAIL:
            begin
                char_c = tail_char(job_reg.tail, job_reg.tail_chr, pos_reg);
                last_c = (pos_reg == tail_len(job_reg.tail) - 3'd1);
            end
            PH_UNIT:
            begin
                case (pos_reg)
                    UP_BSL:  char_c = CH_BSL;
                    UP_U:    char_c = CH_U;
                    UP_NEG:  char_c = CH_MINUS;
                    UP_DIG:  char_c = CH_ZERO + {3'b000, step[19:16]};
                    default: char_c = CH_QMARK;
                endcase
                last_c = (pos_reg == UP_END) && (unit_sel_reg || !two_reg);
            end
            PH_IDLE:
            begin
                char_c = CH_SPACE;
            end
            default:
            begin
                char_c = CH_SPACE;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        phase_next    = phase_reg;
        job_next      = job_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        unit_sel_next = unit_sel_reg;
        two_next      = two_reg;
        neg_next      = neg_reg;
        cur_next      = cur_reg;
        u1_next       = u1_reg;
        mag_next      = mag_reg;
        pow_next      = pow_reg;

        head_two = (head.code[20:16] != 5'd0);
        if (head.hex_cnt != 3'd0)
        begin
            first_phase = PH_HEX;
        end
        else if (head.tail == TK_UNIT)
        begin
            first_phase = PH_UNIT;
        end
        else
        begin
            first_phase = PH_TAIL;
        end

        if (adv)
        begin
            unique case (phase_reg)
                PH_HEX:
                begin
                    if (pos_reg != HP_LO)
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                    else if ({1'b0, idx_reg} + 3'd1 < job_reg.hex_cnt)
                    begin
                        idx_next = idx_reg + 2'd1;
                        pos_next = HP_BSL;
                    end
                    else if (job_reg.tail == TK_UNIT)
                    begin
                        phase_next = PH_UNIT;
                        pos_next   = UP_BSL;
                    end
                    else
                    begin
                        phase_next = PH_TAIL;
                        pos_next   = 3'd0;
                    end
                end
                PH_TAIL:
                begin
                    pos_next = pos_reg + 3'd1;
                end
                PH_UNIT:
                begin
                    case (pos_reg)
                        UP_BSL:
                        begin
                            neg_next = cur_reg[15];
                            mag_next = cur_reg[15] ? 16'(17'h10000 - {1'b0, cur_reg}) : cur_reg;
                            pos_next = UP_U;
                        end
                        UP_U:
                        begin
                            if (mag_reg >= 16'd10000)
                            begin
                                pow_next = 3'd4;
                            end
                            else if (mag_reg >= 16'd1000)
                            begin
                                pow_next = 3'd3;
                            end
                            else if (mag_reg >= 16'd100)
                            begin
                                pow_next = 3'd2;
                            end
                            else if (mag_reg >= 16'd10)
                            begin
                                pow_next = 3'd1;
                            end
                            else
                            begin
                                pow_next = 3'd0;
                            end
                            pos_next = neg_reg ? UP_NEG : UP_DIG;
                        end
                        UP_NEG:
                        begin
                            pos_next = UP_DIG;
                        end
                        UP_DIG:
                        begin
                            mag_next = step[15:0];
                            if (pow_reg == 3'd0)
                            begin
                                pos_next = UP_END;
                            end
                            else
                            begin
                                pow_next = pow_reg - 3'd1;
                            end
                        end
                        default:
                        begin
                            unit_sel_next = 1'b1;
                            cur_next      = u1_reg;
                            pos_next      = UP_BSL;
                        end
                    endcase
                end
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
            if (last_c)
            begin
                phase_next = PH_IDLE;
            end
        end

        // take the next job
        if (pop)
        begin
            job_next      = head;
            phase_next    = first_phase;
            idx_next      = 2'd0;
            pos_next      = 3'd0;
            unit_sel_next = 1'b0;
            two_next      = head_two;
            cur_next      = head_two ? 16'hD800 + {5'd0, head.code[20:10] - 11'd64}
                                     : head.code[15:0];
            u1_next       = 16'hDC00 | {6'd0, head.code[9:0]};
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (adv)
        begin
            out_valid_next         = 1'b1;
            out_item_next.out_char = char_c;
            out_item_next.run_last = last_c;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // job payload and digit state
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        job_reg      <= job_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        unit_sel_reg <= unit_sel_next;
        two_reg      <= two_next;
        neg_reg      <= neg_next;
        cur_reg      <= cur_next;
        u1_reg       <= u1_next;
        mag_reg      <= mag_next;
        pow_reg      <= pow_next;
    end

endmodule

### rtl/utf8_to_rtf_escape_encoder_unit.sv
// UTF-8 to RTF escape encoder.
// Input channel (in_valid, in_ready, in_item) takes one byte of UTF-8 text
// per transaction, with end_of_text on the last byte of a text. Output
// channel (out_valid, out_ready, out_item) gives one ASCII character per
// transaction; run_last marks the last character caused by an input byte.
// Bytes that cause no character (control bytes, lead and middle bytes of a
// sequence) give no output transaction.
// The front decodes a byte in the cycle it is accepted and queues a job; it
// takes one byte per cycle while the job queue has room. The back emits one
// character per cycle while the receiver does not stall, and a byte holds the
// back until its last character is out; plain ASCII runs at one byte per cycle.
// A byte's first character passes the queue, the job register and the output register.
// A stalled receiver holds the output register; the back then stops, the
// queue fills and in_ready falls once QUEUE_DEPTH jobs wait.
// Reset empties the queue, closes any open sequence and drops the output.
module utf8_to_rtf_escape_encoder_unit
    import u2r_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic             accept;
    job_t             push_job;
    logic             push;
    logic             full;
    logic             empty;
    logic             pop;
    logic [JOB_W-1:0] head_bits;
    job_t             head;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;
    assign head     = job_t'(head_bits);

    // byte decode and sequence tracking
    u2r_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (in_item),
        .job      (push_job),
        .job_push (push)
    );

    // job queue between decode and emission
    u2r_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (JOB_W'(push_job)),
        .full      (full),
        .pop       (pop),
        .pop_data  (head_bits),
        .empty     (empty)
    );

    // character emission
    u2r_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

### rtl/u2r_checker.sv
module u2r_checker
    import u2r_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_item,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output transaction changed while stalled");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid right after reset");

    // no output character below 0x20 (space)
    a_printable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.out_char >= 7'h20)
        else $error("non-printable output character");

    // characters of one byte come without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_item.run_last |=> out_valid)
        else $error("gap inside the characters of one byte");

endmodule

bind utf8_to_rtf_escape_encoder_unit u2r_checker u_checker (.*);
